// ----- hw/rtl/mdp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mdp_pkg
// Shared constants and types for the modular dot product block.
// ----------------------------------------------------------------------------
package mdp_pkg;

	// exact running sum, low and high 64-bit words
	localparam int ACC_BITS      = 128;
	localparam int RED_CNT_BITS  = $clog2(ACC_BITS);

	// product queue between multiplier front and accumulate/reduce back
	localparam int FIFO_DEPTH    = 4;
	localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

	// config port
	localparam int APB_DATA_BITS = 64;
	localparam int APB_ADDR_BITS = 4;
	localparam int REG_LSB       = 3;

	typedef logic [APB_ADDR_BITS-1-REG_LSB:0] reg_idx_t;
	localparam reg_idx_t REG_MODULUS = '0;

	typedef enum logic [2:0] {
		ST_ACC  = 3'b001,
		ST_RED  = 3'b010,
		ST_HOLD = 3'b100
	} back_state_t;

endpackage
`default_nettype wire

// ----- hw/rtl/mdp_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mdp_fifo
// Small flop-based queue carrying product beats from front to back.
// ----------------------------------------------------------------------------
module mdp_fifo #(
	parameter int WIDTH = 101,
	parameter int DEPTH = 4
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	input  wire logic [WIDTH-1:0]           push_data,
	input  wire logic                       pop,
	output logic      [WIDTH-1:0]           pop_data,
	output logic      [$clog2(DEPTH+1)-1:0] count,
	output logic                            empty
);

	localparam int IDX_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]    mem_q [DEPTH];
	logic [IDX_BITS-1:0] wr_ptr_q;
	logic [IDX_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == IDX_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == IDX_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign pop_data = mem_q[rd_ptr_q];
	assign count    = count_q;
	assign empty    = (count_q == '0);

endmodule
`default_nettype wire

// ----- hw/rtl/mdp_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mdp_front
// Input side: takes operand beats and forms the exact product in two stages
// (half-width partial products, then combine), pushing into the queue.
// ----------------------------------------------------------------------------
module mdp_front #(
	parameter int VALUE_BITS = 50
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              item_valid,
	output logic                                   item_stall,
	input  wire logic [VALUE_BITS-1:0]             left_value,
	input  wire logic [VALUE_BITS-1:0]             right_value,
	input  wire logic                              last,
	input  wire logic [mdp_pkg::FIFO_CNT_BITS-1:0] fifo_count,
	output logic                                   push,
	output logic      [2*VALUE_BITS:0]             push_data
);

	localparam int LO_BITS   = (VALUE_BITS + 1) / 2;
	localparam int HI_BITS   = VALUE_BITS - LO_BITS;
	localparam int PROD_BITS = 2 * VALUE_BITS;
	localparam int USED_BITS = mdp_pkg::FIFO_CNT_BITS + 1;

	logic [LO_BITS-1:0] a_lo, b_lo;
	logic [HI_BITS-1:0] a_hi, b_hi;
	logic [USED_BITS-1:0] used;
	logic accept;

	logic                         v_s1, last_s1;
	logic [2*LO_BITS-1:0]         p00_s1;
	logic [LO_BITS+HI_BITS-1:0]   p01_s1, p10_s1;
	logic [2*HI_BITS-1:0]         p11_s1;
	logic                         v_s2, last_s2;
	logic [PROD_BITS-1:0]         prod_s2;

	// credit check: queue entries plus beats still in the multiplier
	assign used = USED_BITS'(fifo_count) + USED_BITS'(v_s1) + USED_BITS'(v_s2);
	assign item_stall = (used >= USED_BITS'(mdp_pkg::FIFO_DEPTH));
	assign accept = item_valid && !item_stall;

	assign a_lo = left_value[LO_BITS-1:0];
	assign a_hi = left_value[VALUE_BITS-1:LO_BITS];
	assign b_lo = right_value[LO_BITS-1:0];
	assign b_hi = right_value[VALUE_BITS-1:LO_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1 <= last;
			p00_s1  <= (2*LO_BITS)'(a_lo) * (2*LO_BITS)'(b_lo);
			p01_s1  <= (LO_BITS+HI_BITS)'(a_lo) * (LO_BITS+HI_BITS)'(b_hi);
			p10_s1  <= (LO_BITS+HI_BITS)'(a_hi) * (LO_BITS+HI_BITS)'(b_lo);
			p11_s1  <= (2*HI_BITS)'(a_hi) * (2*HI_BITS)'(b_hi);
		end
		if (v_s1) begin
			last_s2 <= last_s1;
			prod_s2 <= PROD_BITS'(p00_s1)
				+ ((PROD_BITS'(p01_s1) + PROD_BITS'(p10_s1)) << LO_BITS)
				+ (PROD_BITS'(p11_s1) << (2 * LO_BITS));
		end
	end

	assign push      = v_s2;
	assign push_data = {last_s2, prod_s2};

endmodule
`default_nettype wire

// ----- hw/rtl/mdp_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mdp_back
// Accumulates products into the 128-bit sum; on a last beat reduces the sum
// modulo n one bit per cycle (restoring shift-subtract) and holds the result.
// ----------------------------------------------------------------------------
module mdp_back #(
	parameter int VALUE_BITS = 50
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  empty,
	input  wire logic [2*VALUE_BITS:0] pop_data,
	output logic                       pop,
	input  wire logic [VALUE_BITS-1:0] modulus,
	output logic                       dot_valid,
	input  wire logic                  dot_stall,
	output logic      [VALUE_BITS-1:0] dot_residue
);

	localparam int PROD_BITS = 2 * VALUE_BITS;
	localparam int ACC_BITS  = mdp_pkg::ACC_BITS;
	localparam int CNT_BITS  = mdp_pkg::RED_CNT_BITS;

	mdp_pkg::back_state_t state_q;
	logic [ACC_BITS-1:0]   acc_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic [VALUE_BITS-1:0] rem_q;
	logic                  dot_valid_q;
	logic [VALUE_BITS-1:0] dot_residue_q;

	logic                  pop_last;
	logic [PROD_BITS-1:0]  pop_prod;
	logic [VALUE_BITS:0]   rs, diff;
	logic [VALUE_BITS-1:0] rem_next;
	logic                  load_out;

	assign pop      = (state_q == mdp_pkg::ST_ACC) && !empty;
	assign pop_last = pop_data[PROD_BITS];
	assign pop_prod = pop_data[PROD_BITS-1:0];

	assign rs       = {rem_q, acc_q[ACC_BITS-1]};
	assign diff     = rs - {1'b0, modulus};
	assign rem_next = (rs >= {1'b0, modulus}) ? diff[VALUE_BITS-1:0] : rs[VALUE_BITS-1:0];

	assign load_out = (state_q == mdp_pkg::ST_HOLD) && (!dot_valid_q || !dot_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mdp_pkg::ST_ACC;
			acc_q       <= '0;
			cnt_q       <= '0;
			dot_valid_q <= 1'b0;
		end else begin
			case (state_q)
				mdp_pkg::ST_ACC: begin
					if (pop) begin
						acc_q <= acc_q + ACC_BITS'(pop_prod);
						if (pop_last) begin
							cnt_q   <= '0;
							state_q <= mdp_pkg::ST_RED;
						end
					end
				end
				mdp_pkg::ST_RED: begin
					// shifting out the sum leaves it cleared for the next vector
					acc_q <= acc_q << 1;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_BITS'(ACC_BITS - 1)) begin
						state_q <= mdp_pkg::ST_HOLD;
					end
				end
				mdp_pkg::ST_HOLD: begin
					if (load_out) begin
						state_q <= mdp_pkg::ST_ACC;
					end
				end
				default: state_q <= mdp_pkg::ST_ACC;
			endcase

			if (load_out) begin
				dot_valid_q <= 1'b1;
			end else if (!dot_stall) begin
				dot_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && pop_last) begin
			rem_q <= '0;
		end else if (state_q == mdp_pkg::ST_RED) begin
			rem_q <= rem_next;
		end
		if (load_out) begin
			dot_residue_q <= (modulus == '0) ? '0 : rem_q;
		end
	end

	assign dot_valid   = dot_valid_q;
	assign dot_residue = dot_residue_q;

endmodule
`default_nettype wire

// ----- hw/rtl/modular_dot_product.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// modular_dot_product
// Dot product of two unsigned vectors modulo a configured n, exact 128-bit
// accumulation, residue emitted on the last element pair.
// ----------------------------------------------------------------------------
//  channel  dir  handshake               payload
//  item     in   item_valid/item_stall   left_value, right_value, last
//  dot      out  dot_valid/dot_stall     dot_residue
//  cfg      in   APB psel/penable/pready paddr, pwdata, prdata (modulus @ 0x0)
//
//  One beat per cycle, unless item_stall, for pairs not marked last; products
//  pass the partial-product and combine registers into the queue. A last beat
//  starts a bit-serial reduction of the 128-bit sum, then the output register is
//  loaded; the queue takes up to 4 beats meanwhile. Reset: modulus 2, sum zero.
//  A stalled result holds in the output register; the next residue waits behind it.
// ----------------------------------------------------------------------------
module modular_dot_product #(
	parameter int VALUE_BITS = 50
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  item_valid,
	output logic                                       item_stall,
	input  wire logic [VALUE_BITS-1:0]                 left_value,
	input  wire logic [VALUE_BITS-1:0]                 right_value,
	input  wire logic                                  last,
	output logic                                       dot_valid,
	input  wire logic                                  dot_stall,
	output logic      [VALUE_BITS-1:0]                 dot_residue,
	input  wire logic                                  psel,
	input  wire logic                                  penable,
	input  wire logic                                  pwrite,
	input  wire logic [mdp_pkg::APB_ADDR_BITS-1:0]     paddr,
	input  wire logic [mdp_pkg::APB_DATA_BITS-1:0]     pwdata,
	output logic      [mdp_pkg::APB_DATA_BITS-1:0]     prdata,
	output logic                                       pready
);

	localparam int QW = 2 * VALUE_BITS + 1;

	logic [VALUE_BITS-1:0]             modulus_q;
	mdp_pkg::reg_idx_t                 reg_idx;
	logic                              push, pop, empty;
	logic [QW-1:0]                     push_data, pop_data;
	logic [mdp_pkg::FIFO_CNT_BITS-1:0] fifo_count;

	assign pready  = 1'b1;
	assign reg_idx = paddr[mdp_pkg::APB_ADDR_BITS-1:mdp_pkg::REG_LSB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= VALUE_BITS'(2);
		end else if (psel && penable && pwrite && pready
				&& reg_idx == mdp_pkg::REG_MODULUS) begin
			modulus_q <= pwdata[VALUE_BITS-1:0];
		end
	end

	assign prdata = (reg_idx == mdp_pkg::REG_MODULUS)
		? mdp_pkg::APB_DATA_BITS'(modulus_q) : '0;

	mdp_front #(
		.VALUE_BITS(VALUE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.left_value (left_value),
		.right_value(right_value),
		.last       (last),
		.fifo_count (fifo_count),
		.push       (push),
		.push_data  (push_data)
	);

	mdp_fifo #(
		.WIDTH(QW),
		.DEPTH(mdp_pkg::FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.pop_data (pop_data),
		.count    (fifo_count),
		.empty    (empty)
	);

	mdp_back #(
		.VALUE_BITS(VALUE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.empty      (empty),
		.pop_data   (pop_data),
		.pop        (pop),
		.modulus    (modulus_q),
		.dot_valid  (dot_valid),
		.dot_stall  (dot_stall),
		.dot_residue(dot_residue)
	);

endmodule
`default_nettype wire

// ----- verif/modular_dot_product_tb.sv -----
// ----------------------------------------------------------------------------
// modular_dot_product_tb
// Streams element pairs into the dot product block and checks every residue
// beat against a 128-bit exact model of the sum mod the shadowed modulus, or a
// directed row's expected value. Directed rows come first, then random vectors
// under several modulus settings, random gaps and output stalls (not in phase 3).
// ----------------------------------------------------------------------------
module modular_dot_product_tb;

	localparam int VB              = 50;
	localparam int ITEMS_PER_PHASE = 200;
	localparam int N_PHASES        = 8;
	localparam int DRAIN_CYCLES    = 160;
	localparam int WATCHDOG_LIMIT  = 4000;

	typedef logic [VB-1:0] val_t;

	localparam val_t              VAL_MAX    = '1;
	localparam val_t              VAL_MAX_M1 = VAL_MAX - 1;
	localparam mdp_pkg::reg_idx_t REG_UNUSED = mdp_pkg::reg_idx_t'(1);

	typedef enum logic {ROW_PAIR, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t         kind;
		mdp_pkg::reg_idx_t idx;
		logic [63:0]       cfg;
		val_t              lval;
		val_t              rval;
		logic              lst;
		logic              typed;
		val_t              want;
	} stim_row_t;

	localparam int N_DIRECTED = 24;

	stim_row_t directed_rows [N_DIRECTED] = '{
		// reset modulus 2
		'{ROW_PAIR, mdp_pkg::REG_MODULUS, 64'd0,
			VAL_MAX, VAL_MAX, 1'b1, 1'b1, val_t'(1)},
		'{ROW_PAIR, mdp_pkg::REG_MODULUS, 64'd0,
			val_t'(0), VAL_MAX, 1'b1, 1'b1, val_t'(0)},
		'{ROW_PAIR, mdp_pkg::REG_MODULUS, 64'd0,
			VAL_MAX, val_t'(0), 1'b1, 1'b1, val_t'(0)},
		'{ROW_PAIR, mdp_pkg::REG_MODULUS, 64'd0,
			val_t'(0), val_t'(0), 1'b1, 1'b1, val_t'(0)},
		'{ROW_PAIR, mdp_pkg::REG_MODULUS, 64'd0,
			VAL_MAX, val_t'(1), 1'b0, 1'b0, val_t'(0)},
		'{ROW_PAIR, mdp_pkg::REG_MODULUS, 64'd0,
			val_t'(1), val_t'(1), 1'b1, 1'b0, val_t'(0)},
		// largest modulus
		'{ROW_CFG, mdp_pkg::REG_MODULUS, 64'(VAL_MAX),
			val_t'(0), val_t'(0), 1'b0, 1'b0, val_t'(0)},
		'{ROW_PAIR, mdp_pkg::REG_MODULUS, 64'd0,
			VAL_MAX, VAL_MAX, 1'b1, 1'b1, val_t'(0)},
		'{ROW_PAIR, mdp_pkg::REG_MODULUS, 64'd0,
			val_t'(1), VAL_MAX_M1, 1'b1, 1'b1, VAL_MAX_M1},
		'{ROW_PAIR, mdp_pkg::REG_MODULUS, 64'd0,
			VAL_MAX, VAL_MAX, 1'b0, 1'b0, val_t'(0)},
		'{ROW_PAIR, mdp_pkg::REG_MODULUS, 64'd0,
			VAL_MAX, VAL_MAX, 1'b0, 1'b0, val_t'(0)},
		'{ROW_PAIR, mdp_pkg::REG_MODULUS, 64'd0,
			VAL_MAX, VAL_MAX, 1'b0, 1'b0, val_t'(0)},
		'{ROW_PAIR, mdp_pkg::REG_MODULUS, 64'd0,
			val_t'(1), val_t'(1), 1'b1, 1'b1, val_t'(1)},
		// modulus one
		'{ROW_CFG, mdp_pkg::REG_MODULUS, 64'd1,
			val_t'(0), val_t'(0), 1'b0, 1'b0, val_t'(0)},
		'{ROW_PAIR, mdp_pkg::REG_MODULUS, 64'd0,
			50'h2_A5A5_5A5A_3C3C, 50'h1_5A5A_A5A5_C3C3, 1'b1, 1'b1, val_t'(0)},
		// upper bits only: masks to modulus zero
		'{ROW_CFG, mdp_pkg::REG_MODULUS, 64'hFFFC_0000_0000_0000,
			val_t'(0), val_t'(0), 1'b0, 1'b0, val_t'(0)},
		'{ROW_PAIR, mdp_pkg::REG_MODULUS, 64'd0,
			VAL_MAX, VAL_MAX, 1'b1, 1'b1, val_t'(0)},
		// write outside the register map is dropped, modulus stays zero
		'{ROW_CFG, REG_UNUSED, 64'd5,
			val_t'(0), val_t'(0), 1'b0, 1'b0, val_t'(0)},
		'{ROW_PAIR, mdp_pkg::REG_MODULUS, 64'd0,
			val_t'(3), val_t'(3), 1'b1, 1'b1, val_t'(0)},
		// operands above the modulus
		'{ROW_CFG, mdp_pkg::REG_MODULUS, 64'h2_0000_0000_0000,
			val_t'(0), val_t'(0), 1'b0, 1'b0, val_t'(0)},
		'{ROW_PAIR, mdp_pkg::REG_MODULUS, 64'd0,
			VAL_MAX, VAL_MAX, 1'b0, 1'b0, val_t'(0)},
		'{ROW_PAIR, mdp_pkg::REG_MODULUS, 64'd0,
			50'h2_0000_0000_0007, val_t'(3), 1'b1, 1'b0, val_t'(0)},
		'{ROW_CFG, mdp_pkg::REG_MODULUS, 64'd3,
			val_t'(0), val_t'(0), 1'b0, 1'b0, val_t'(0)},
		'{ROW_PAIR, mdp_pkg::REG_MODULUS, 64'd0,
			val_t'(7), val_t'(11), 1'b1, 1'b0, val_t'(0)}
	};

	logic                              clk;
	logic                              arst_n;
	logic                              item_valid;
	logic                              item_stall;
	val_t                              left_value;
	val_t                              right_value;
	logic                              last;
	logic                              dot_valid;
	logic                              dot_stall = 1'b0;
	val_t                              dot_residue;
	logic                              psel;
	logic                              penable;
	logic                              pwrite;
	logic [mdp_pkg::APB_ADDR_BITS-1:0] paddr;
	logic [mdp_pkg::APB_DATA_BITS-1:0] pwdata;
	logic [mdp_pkg::APB_DATA_BITS-1:0] prdata;
	logic                              pready;

	logic         quiet = 1'b0;
	logic [127:0] running_sum;
	val_t         modulus_shadow;
	val_t         residues_due [$];
	int           mismatches = 0;
	int           idle_cycles = 0;

	modular_dot_product #(
		.VALUE_BITS(VB)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.left_value  (left_value),
		.right_value (right_value),
		.last        (last),
		.dot_valid   (dot_valid),
		.dot_stall   (dot_stall),
		.dot_residue (dot_residue),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch: %s got %h want %h", what, got, want);
		mismatches++;
	endtask

	// exact sum of products; residue queued on the last pair
	task automatic fold_pair(input val_t lval, input val_t rval, input logic lst,
			input logic typed, input val_t want);
		logic [127:0] rem;
		running_sum = running_sum + 128'(lval) * 128'(rval);
		if (lst) begin
			rem = (modulus_shadow == '0) ? '0 : running_sum % 128'(modulus_shadow);
			residues_due.push_back(typed ? want : val_t'(rem));
			running_sum = '0;
		end
	endtask

	function automatic val_t rand_value();
		logic [63:0] w;
		w = {$urandom, $urandom};
		case ($urandom_range(9))
			0: return '0;
			1: return VAL_MAX;
			2: return val_t'($urandom_range(255));
			3: return (modulus_shadow == '0) ? w[VB-1:0] : val_t'(w % 64'(modulus_shadow));
			default: return w[VB-1:0];
		endcase
	endfunction

	task automatic send_pair(input val_t lval, input val_t rval, input logic lst,
			input logic typed, input val_t want);
		while (!quiet && $urandom_range(99) < 16) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid  <= 1'b1;
		left_value  <= lval;
		right_value <= rval;
		last        <= lst;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		fold_pair(lval, rval, lst, typed, want);
		@(negedge clk);
	endtask

	task automatic settle();
		item_valid <= 1'b0;
		while (residues_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic apb_xfer(input logic wr, input mdp_pkg::reg_idx_t idx,
			input logic [63:0] wdata, output logic [63:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, {mdp_pkg::REG_LSB{1'b0}}};
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic cfg_write(input mdp_pkg::reg_idx_t idx, input logic [63:0] value);
		logic [63:0] rd;
		settle();
		apb_xfer(1'b1, idx, value, rd);
		if (idx == mdp_pkg::REG_MODULUS)
			modulus_shadow = value[VB-1:0];
		apb_xfer(1'b0, mdp_pkg::REG_MODULUS, '0, rd);
		if (rd !== 64'(modulus_shadow))
			report_mismatch("modulus readback", rd, 64'(modulus_shadow));
	endtask

	always @(negedge clk) begin
		dot_stall <= !quiet && ($urandom_range(99) < 16);
	end

	always @(posedge clk) begin
		if (arst_n && dot_valid && !dot_stall) begin
			if (residues_due.size() == 0)
				report_mismatch("dot beat with none due", 64'(dot_residue), 64'd0);
			else if (dot_residue !== residues_due[0]) begin
				report_mismatch("dot_residue", 64'(dot_residue), 64'(residues_due[0]));
				void'(residues_due.pop_front());
			end else
				void'(residues_due.pop_front());
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (dot_valid && !dot_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		logic [63:0] mod_word;
		int          sent;
		int          len;
		arst_n         = 1'b0;
		item_valid     = 1'b0;
		left_value     = '0;
		right_value    = '0;
		last           = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		running_sum    = '0;
		modulus_shadow = val_t'(2);
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG)
				cfg_write(directed_rows[i].idx, directed_rows[i].cfg);
			else
				send_pair(directed_rows[i].lval, directed_rows[i].rval,
					directed_rows[i].lst, directed_rows[i].typed, directed_rows[i].want);
		end

		for (int p = 0; p < N_PHASES; p++) begin
			case (p)
				0: mod_word = {$urandom, $urandom};
				1: mod_word = 64'(VAL_MAX);
				2: mod_word = 64'd2;
				3: mod_word = 64'($urandom_range(1000, 3));
				4: mod_word = 64'd1;
				5: mod_word = {$urandom, $urandom};
				6: mod_word = 64'h2_0000_0000_0000 | 64'($urandom_range(15));
				default: mod_word = 64'(VAL_MAX) - 64'($urandom_range(255));
			endcase
			if (p == 5)
				cfg_write(REG_UNUSED, {$urandom, $urandom});
			cfg_write(mdp_pkg::REG_MODULUS, mod_word);
			quiet = (p == 3);
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				len = ($urandom_range(99) < 85) ? $urandom_range(6, 1) : $urandom_range(48, 7);
				for (int k = 0; k < len; k++) begin
					send_pair(rand_value(), rand_value(), k == len - 1, 1'b0, '0);
					sent++;
				end
				// hold off until every residue is out
				if ($urandom_range(24) == 0) begin
					item_valid <= 1'b0;
					while (residues_due.size() != 0)
						@(negedge clk);
				end
			end
			quiet = 1'b0;
		end

		settle();
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- modular_dot_product.f -----
hw/rtl/mdp_pkg.sv
hw/rtl/mdp_fifo.sv
hw/rtl/mdp_front.sv
hw/rtl/mdp_back.sv
hw/rtl/modular_dot_product.sv
verif/modular_dot_product_tb.sv
